// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int unsigned KEY_W           = 32;
    localparam int unsigned VAL_W           = 32;
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned STAMP_W         = 48;
    localparam int unsigned CAP_W           = 5;
    localparam int unsigned ENTRIES_DEFAULT = 16;
    // slot index and fill fields sized for the largest supported row (256)
    localparam int unsigned SLOT_W          = 8;
    localparam int unsigned FILL_W          = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_out;

    // running lookup record handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic [KEY_W-1:0]   key;
        logic               hit;
        logic [SLOT_W-1:0]  hit_idx;
        logic [VAL_W-1:0]   hit_val;
        logic               free;
        logic [SLOT_W-1:0]  free_idx;
        logic               vic;
        logic [SLOT_W-1:0]  vic_idx;
        logic [CNT_W-1:0]   vic_cnt;
        logic [STAMP_W-1:0] vic_stamp;
        logic [FILL_W-1:0]  fill;
    } t_scan;

    // commit broadcast to the row
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  idx;
        logic               insert;
        logic               wr_val;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [STAMP_W-1:0] stamp;
    } t_upd;

endpackage

// ----- src/lfu_cell.sv -----
// ----------------------------------------------------------------------------
// lfu_cell
// One cache slot: holds its entry and folds it into the passing lookup record.
// ----------------------------------------------------------------------------
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_scan i_scan,
    input  t_upd  i_upd,
    output t_scan o_scan
);

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [CNT_W-1:0]   r_cnt;
    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_scan;
    t_scan              n_scan;

    logic take_hit;
    logic take_vic;
    logic sel;

    always_comb begin
        n_scan   = i_scan;
        take_hit = r_valid && !i_scan.hit && (r_key == i_scan.key);
        take_vic = r_valid && (!i_scan.vic || (r_cnt < i_scan.vic_cnt) ||
                   ((r_cnt == i_scan.vic_cnt) && (r_stamp < i_scan.vic_stamp)));
        if (take_hit) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = MY_IDX;
            n_scan.hit_val = r_value;
        end
        if (take_vic) begin
            n_scan.vic       = 1'b1;
            n_scan.vic_idx   = MY_IDX;
            n_scan.vic_cnt   = r_cnt;
            n_scan.vic_stamp = r_stamp;
        end
        if (r_valid) begin
            n_scan.fill = i_scan.fill + FILL_W'(1);
        end else if (!i_scan.free) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign sel = i_upd.en && (i_upd.idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_upd.insert) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_stamp <= i_upd.stamp;
            if (i_upd.wr_val) begin
                r_value <= i_upd.value;
            end
            if (i_upd.insert) begin
                r_key <= i_upd.key;
                r_cnt <= CNT_W'(1);
            end else if (r_cnt != CNT_MAX) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_scan = r_scan;

endmodule

// ----- src/lfu_cache_lookup_replace_top.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_lookup_replace_top
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break, built as a row of slot cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | i_in_valid/o_in_ready  | t_in  {cmd, key, value}
//  out     | output    | o_out_valid/i_out_ready| t_out {found, read_value,
//          |           |                        |        evicted}
//  cfg     | input     | i_cfg_valid/o_cfg_ready| capacity, 5 bits
//
// A request word walks the row of ENTRIES cells, one cell per cycle, picking
// up the hit, first free slot, victim and fill count. The record from the
// tail is registered, then in the commit state the decision is broadcast back
// to the row and the result lands in the output register; a stalled output
// holds the commit. Capacity zero skips the walk. Reset is synchronous, active
// low: all slots invalid, access clock zero, capacity 16. A new word is taken
// only in the idle state, once the previous one has committed.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_replace_top
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_capacity;
    logic [STAMP_W-1:0] r_clock;
    t_in                r_req;
    logic               r_zero;
    t_scan              r_scan;
    logic               r_out_valid;
    t_out               r_out;

    t_scan              w_scan [ENTRIES+1];
    t_scan              w_head;
    t_upd               w_upd;

    logic [FILL_W-1:0]  cap_eff;
    logic               in_acc;
    logic               fire;
    logic               do_hit;
    logic               do_ins;
    logic               full;
    t_out               n_out;

    // effective capacity saturates at the row length
    assign cap_eff = (FILL_W'(r_capacity) > FILL_W'(ENTRIES)) ?
                     FILL_W'(ENTRIES) : FILL_W'(r_capacity);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    // record injected at the head of the row
    always_comb begin
        w_head     = '0;
        w_head.vld = in_acc && (cap_eff != '0);
        w_head.key = i_in_data.key;
    end

    assign w_scan[0] = w_head;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (w_scan[g]),
            .i_upd   (w_upd),
            .o_scan  (w_scan[g+1])
        );
    end

    // decision on the record that left the tail of the row
    always_comb begin
        fire   = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
        do_hit = !r_zero && r_scan.hit;
        full   = (r_scan.fill >= cap_eff) || !r_scan.free;
        do_ins = !r_zero && !r_scan.hit && (r_req.cmd == CMD_PUT) &&
                 (!full || r_scan.vic);

        w_upd        = '0;
        w_upd.en     = fire && (do_hit || do_ins);
        w_upd.idx    = do_hit ? r_scan.hit_idx :
                       (full ? r_scan.vic_idx : r_scan.free_idx);
        w_upd.insert = do_ins;
        w_upd.wr_val = do_ins || (do_hit && (r_req.cmd == CMD_PUT));
        w_upd.key    = r_req.key;
        w_upd.value  = r_req.value;
        w_upd.stamp  = r_clock + STAMP_W'(1);

        n_out            = '0;
        n_out.found      = do_hit;
        n_out.read_value = (do_hit && (r_req.cmd == CMD_GET)) ? r_scan.hit_val : '0;
        n_out.evicted    = do_ins && full;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (cap_eff == '0) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan[ENTRIES].vld) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (w_upd.en) begin
                r_clock <= w_upd.stamp;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_in_data;
            r_zero <= (cap_eff == '0);
        end
        if ((r_state == S_SCAN) && w_scan[ENTRIES].vld) begin
            r_scan <= w_scan[ENTRIES];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_upd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COMMIT) |-> !w_upd.en)
        else $error("slot update outside commit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == S_SCAN) || (r_state == S_COMMIT)))
        else $error("accepted word did not start a lookup");

    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_clock != $past(r_clock)) |->
            ($past(w_upd.en) && (r_clock == $past(r_clock) + STAMP_W'(1))))
        else $error("access clock moved without a touch or insert");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.found && o_out_data.evicted))
        else $error("hit reported together with eviction");

endmodule

// ----- bench/tb_lfu_cache_lookup_replace_top.sv -----
// ----------------------------------------------------------------------------
// tb_lfu_cache_lookup_replace_top
// Self-checking bench for the LFU cache with LRU tie-break. A shadow copy of
// the slot row predicts found / read_value / evicted for every accepted
// request word. Results are compared in order against the predictions, under
// several capacities and with random idling on the input and output sides.
// ----------------------------------------------------------------------------
module tb_lfu_cache_lookup_replace_top
    import lfu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES      = ENTRIES_DEFAULT;
    // quiet time after the last result: a full walk of the row, with margin
    localparam int unsigned SETTLE       = 2 * ENTRIES + 8;
    // cycles with no handshake on any channel before the run is abandoned
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned RANDOM_WORDS = 225;

    // ------------------------------------------------------------------------
    // clock, reset and DUT ports (all driven to known values from time zero)
    // ------------------------------------------------------------------------
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in              i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = CAP_RESET;

    always #10 i_clk = ~i_clk;

    lfu_cache_lookup_replace_top #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // shadow cache: same row of slots, same access clock, same capacity
    // ------------------------------------------------------------------------
    logic               shadow_valid [ENTRIES];
    logic [KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [VAL_W-1:0]   shadow_val   [ENTRIES];
    logic [CNT_W-1:0]   shadow_uses  [ENTRIES];
    logic [STAMP_W-1:0] shadow_stamp [ENTRIES];
    logic [STAMP_W-1:0] shadow_clock;
    logic [CAP_W-1:0]   shadow_capacity;

    t_out expected_results[$];
    int   fail_count    = 0;
    int   send_idle_pct = 0;   // chance per cycle that the sender holds off
    int   stall_pct     = 0;   // chance per cycle that the receiver stalls

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
        end
        shadow_clock    = '0;
        shadow_capacity = CAP_RESET;
    end

    // Applies one request to the shadow row and returns what the block must
    // answer. Hits bump the count (saturating) and take a fresh stamp; a put
    // miss fills the lowest free slot or evicts the least used, oldest entry.
    function automatic t_out cache_access(input t_in req);
        t_out        res;
        int unsigned eff_cap;
        int          hit_slot;
        int          free_slot;
        int          victim;
        int unsigned fill;
        res       = '0;
        eff_cap   = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
        hit_slot  = -1;
        free_slot = -1;
        victim    = -1;
        fill      = 0;
        // capacity zero: nothing changes, not even the access clock
        if (eff_cap == 0) return res;

        for (int i = 0; i < ENTRIES; i++) begin
            if (!shadow_valid[i]) begin
                if (free_slot < 0) free_slot = i;
            end else begin
                fill++;
                if (hit_slot < 0 && shadow_key[i] == req.key) hit_slot = i;
                if (victim < 0 || shadow_uses[i] < shadow_uses[victim] ||
                    (shadow_uses[i] == shadow_uses[victim] &&
                     shadow_stamp[i] < shadow_stamp[victim])) begin
                    victim = i;
                end
            end
        end

        if (hit_slot >= 0) begin
            if (shadow_uses[hit_slot] != CNT_MAX) shadow_uses[hit_slot]++;
            shadow_clock           = shadow_clock + 1'b1;
            shadow_stamp[hit_slot] = shadow_clock;
            res.found              = 1'b1;
            if (t_cmd'(req.cmd) == CMD_PUT) begin
                shadow_val[hit_slot] = req.value;
            end else begin
                res.read_value = shadow_val[hit_slot];
            end
            return res;
        end
        if (t_cmd'(req.cmd) == CMD_GET) return res;

        // full, or over-full after the capacity was lowered: replace a victim
        if (fill >= eff_cap || free_slot < 0) begin
            if (victim < 0) return res;
            free_slot   = victim;
            res.evicted = 1'b1;
        end
        shadow_clock            = shadow_clock + 1'b1;
        shadow_valid[free_slot] = 1'b1;
        shadow_key[free_slot]   = req.key;
        shadow_val[free_slot]   = req.value;
        shadow_uses[free_slot]  = CNT_W'(1);
        shadow_stamp[free_slot] = shadow_clock;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: ready toggles at random per cycle according to stall_pct
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker: every output word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", o_out_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d",
                           want.found, o_out_data.found);
                    fail_count++;
                end
                if (o_out_data.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_out_data.read_value);
                    fail_count++;
                end
                if (o_out_data.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d",
                           want.evicted, o_out_data.evicted);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: counts cycles without a handshake on any channel
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_lfu_cache_lookup_replace_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------

    // Sends one request word. Valid is left high on return so back-to-back
    // words need no gap; it is dropped only by an idle cycle or a drain.
    task automatic send_request(input t_cmd cmd, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        t_in req;
        req.cmd   = cmd;
        req.key   = key;
        req.value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(cache_access(req));
    endtask

    // Stops sending and waits until every predicted word has come back,
    // then lets the row settle so the block is idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Capacity write; only ever issued once the block is drained.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        shadow_capacity  = cap;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // Reset capacity of 16: get on an empty cache, inserts, get hits and a
    // put hit that rewrites the value, with keys and values at their extremes.
    task automatic test_basic_hits();
        send_request(CMD_GET, '0, 32'h1234_5678);
        send_request(CMD_PUT, '0, '1);
        send_request(CMD_GET, '0, '0);
        send_request(CMD_PUT, '1, '0);
        send_request(CMD_GET, '1, '1);
        send_request(CMD_PUT, '0, 32'hA5A5_A5A5);
        send_request(CMD_GET, '0, '0);
    endtask

    // Capacity zero: puts do nothing and gets miss, but held entries survive
    // and are seen again once capacity returns (here above ENTRIES).
    task automatic test_capacity_zero();
        write_capacity(CAP_W'(0));
        send_request(CMD_PUT, 32'h0000_1234, 32'hDEAD_BEEF);
        send_request(CMD_GET, '0, '0);
        write_capacity('1);
        send_request(CMD_GET, '0, '0);
    endtask

    // Two entries with different counts: the less used one goes first.
    task automatic test_lfu_eviction();
        write_capacity(CAP_W'(2));
        send_request(CMD_PUT, 32'd10, 32'h0000_0010);
        send_request(CMD_GET, '1, '0);
        send_request(CMD_PUT, 32'd11, 32'h0000_0011);
        send_request(CMD_GET, 32'd10, '0);
    endtask

    // Equal counts: the entry touched longest ago is the victim.
    task automatic test_lru_tiebreak();
        write_capacity(CAP_W'(3));
        send_request(CMD_PUT, 32'd20, 32'h0000_0020);
        send_request(CMD_PUT, 32'd21, 32'h0000_0021);
        send_request(CMD_GET, 32'd11, '0);
        send_request(CMD_GET, 32'd20, '0);
        send_request(CMD_PUT, 32'd22, 32'h0000_0022);
    endtask

    // Capacity lowered under the fill: lookups still see everything, each
    // put miss swaps one entry out.
    task automatic test_capacity_shrink();
        write_capacity(CAP_W'(1));
        send_request(CMD_GET, '0, '0);
        send_request(CMD_GET, 32'd20, '0);
        send_request(CMD_PUT, 32'd23, 32'h0000_0023);
        send_request(CMD_GET, 32'd22, '0);
    endtask

    // Random traffic over a small key pool, so hits, refills and evictions
    // all happen; a share of fully random keys keeps misses coming.
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap,
                                       input int send_pct, input int recv_pct);
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        t_cmd             cmd;
        pool_size = $urandom_range(24, 2);
        key_pool.push_back('0);
        key_pool.push_back('1);
        for (int i = 2; i < pool_size; i++) key_pool.push_back($urandom);
        write_capacity(cap);
        set_idling(send_pct, recv_pct);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(99) < 85) begin
                key = key_pool[$urandom_range(pool_size - 1)];
            end else begin
                key = $urandom;
            end
            cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
            send_request(cmd, key, $urandom);
        end
        drain_results();
        set_idling(0, 0);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_hits();
        test_capacity_zero();
        test_lfu_eviction();
        test_lru_tiebreak();
        test_capacity_shrink();
        drain_results();

        // each idling style at least twice, capacities across the range
        test_random_traffic(CAP_W'(16), 0, 0);
        test_random_traffic(CAP_W'(4), 85, 0);
        test_random_traffic('1, 0, 85);
        test_random_traffic(CAP_W'(1), 7, 7);
        test_random_traffic(CAP_W'(8), 0, 0);
        test_random_traffic(CAP_W'(0), 85, 0);
        test_random_traffic(CAP_W'(2), 0, 85);
        test_random_traffic(CAP_W'($urandom_range(31, 3)), 7, 7);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_lfu_cache_lookup_replace_top: PASS");
        end else begin
            $display("tb_lfu_cache_lookup_replace_top: FAIL");
        end
        $finish;
    end

endmodule
